// File: hw/rtl/dntw_pkg.sv
package dntw_pkg;

  localparam logic [7:0] DOT_CODE = 8'h2E;
  localparam int LEN_W  = 6;   // label length, up to 63
  localparam int NAME_W = 8;   // name byte count, up to 255
  localparam int POS_W  = 7;   // wire byte position inside one label; a label gives at most 65 bytes

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_EMPTY_LABEL = 2'd1,
    ST_LABEL_LONG  = 2'd2,
    ST_NAME_LONG   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    JOB_LABEL,
    JOB_ROOT,
    JOB_ERR
  } job_kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  typedef struct packed {
    job_kind_t        kind;
    logic             bank;
    logic [LEN_W-1:0] len;
    logic             fin;
    status_t          status;
  } job_t;

  typedef struct packed {
    logic             en;
    logic             bank;
    logic [LEN_W-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } bank_rel_t;

endpackage

// File: hw/rtl/dntw_char_if.sv
interface dntw_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// File: hw/rtl/dntw_res_if.sv
interface dntw_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [1:0] byte_count;
  logic       is_last_res;
  logic [1:0] status;

  modport source (output valid, output first_byte, output second_byte, output byte_count,
                  output is_last_res, output status, input ready);
  modport sink   (input valid, input first_byte, input second_byte, input byte_count,
                  input is_last_res, input status, output ready);
endinterface

// File: hw/rtl/dntw_job_fifo.sv
module dntw_job_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dntw_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output dntw_pkg::job_t pop_job,
  output logic          empty
);

  dntw_pkg::job_t entry_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign pop_job = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> (!full || pop))
    else $error("job queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("job queue read while empty");
`endif

endmodule

// File: hw/rtl/dntw_front.sv
module dntw_front #(
  parameter int LABEL_MAX = 63,
  parameter int NAME_MAX  = 255
) (
  input  logic                clk,
  input  logic                rst_n,
  dntw_char_if.sink           in_ch,
  input  logic                q_full,
  output logic                push,
  output dntw_pkg::job_t      push_job,
  output dntw_pkg::store_wr_t wr,
  input  dntw_pkg::bank_rel_t rel
);

  logic [dntw_pkg::LEN_W-1:0]  lc_r, lc_nxt;
  logic [dntw_pkg::NAME_W-1:0] nc_r, nc_nxt;
  logic                        start_r, start_nxt;
  logic                        disc_r, disc_nxt;
  logic                        wb_r, wb_nxt;
  logic [1:0]                  busy_r, busy_nxt;

  logic                        acc;
  logic                        is_dot;
  logic [dntw_pkg::LEN_W-1:0]  close_len;
  logic [9:0]                  close_total;
  logic                        close_over;

  assign in_ch.ready = !q_full && !busy_r[wb_r];
  assign acc         = in_ch.valid && in_ch.ready;
  assign is_dot      = (in_ch.char_code == dntw_pkg::DOT_CODE);
  assign close_len   = is_dot ? lc_r : lc_r + 1'b1;
  assign close_total = {2'b00, nc_r} + {4'b0000, close_len} + 10'd2;
  assign close_over  = (close_total > 10'(NAME_MAX));

  always_comb begin
    lc_nxt    = lc_r;
    nc_nxt    = nc_r;
    start_nxt = start_r;
    disc_nxt  = disc_r;
    wb_nxt    = wb_r;
    busy_nxt  = busy_r;
    push      = 1'b0;
    push_job  = '0;
    wr        = '0;

    if (rel.en) begin
      busy_nxt[rel.bank] = 1'b0;
    end

    if (acc) begin
      priority if (disc_r) begin
        // drop the rest of a failed name
        if (in_ch.is_last) begin
          disc_nxt  = 1'b0;
          start_nxt = 1'b1;
        end
      end else if (is_dot && start_r && in_ch.is_last) begin
        push          = 1'b1;
        push_job.kind = dntw_pkg::JOB_ROOT;
        push_job.fin  = 1'b1;
        lc_nxt        = '0;
        nc_nxt        = '0;
        start_nxt     = 1'b1;
      end else if ((is_dot && lc_r == '0) ||
                   (!is_dot && lc_r >= dntw_pkg::LEN_W'(LABEL_MAX)) ||
                   ((is_dot || in_ch.is_last) && close_over)) begin
        push            = 1'b1;
        push_job.kind   = dntw_pkg::JOB_ERR;
        push_job.fin    = 1'b1;
        if (is_dot && lc_r == '0) begin
          push_job.status = dntw_pkg::ST_EMPTY_LABEL;
        end else if (!is_dot && lc_r >= dntw_pkg::LEN_W'(LABEL_MAX)) begin
          push_job.status = dntw_pkg::ST_LABEL_LONG;
        end else begin
          push_job.status = dntw_pkg::ST_NAME_LONG;
        end
        lc_nxt    = '0;
        nc_nxt    = '0;
        start_nxt = 1'b1;
        disc_nxt  = !in_ch.is_last;
      end else begin
        start_nxt = 1'b0;
        if (!is_dot) begin
          wr.en   = 1'b1;
          wr.bank = wb_r;
          wr.addr = lc_r;
          wr.data = in_ch.char_code;
          lc_nxt  = lc_r + 1'b1;
        end
        if (is_dot || in_ch.is_last) begin
          // hand the label to the back end and switch banks
          push             = 1'b1;
          push_job.kind    = dntw_pkg::JOB_LABEL;
          push_job.bank    = wb_r;
          push_job.len     = close_len;
          push_job.fin     = in_ch.is_last;
          push_job.status  = dntw_pkg::ST_OK;
          busy_nxt[wb_r]   = 1'b1;
          wb_nxt           = !wb_r;
          lc_nxt           = '0;
          nc_nxt           = dntw_pkg::NAME_W'(close_total - 10'd1);
          if (in_ch.is_last) begin
            nc_nxt    = '0;
            start_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lc_r    <= '0;
      nc_r    <= '0;
      start_r <= 1'b1;
      disc_r  <= 1'b0;
      wb_r    <= 1'b0;
      busy_r  <= 2'b00;
    end else begin
      lc_r    <= lc_nxt;
      nc_r    <= nc_nxt;
      start_r <= start_nxt;
      disc_r  <= disc_nxt;
      wb_r    <= wb_nxt;
      busy_r  <= busy_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_wr_free_bank: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> !busy_r[wr.bank])
    else $error("label write into a bank still being drained");
  a_rel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rel.en |-> busy_r[rel.bank])
    else $error("release of a bank that is not held");
`endif

endmodule

// File: hw/rtl/dntw_back.sv
module dntw_back #(
  parameter int LABEL_MAX = 63
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dntw_pkg::store_wr_t wr,
  input  logic                q_empty,
  input  dntw_pkg::job_t      q_job,
  output logic                pop,
  output dntw_pkg::bank_rel_t rel,
  dntw_res_if.source          out_ch
);

  localparam int AW = $clog2(2 * LABEL_MAX);

  logic [7:0] mem [2 * LABEL_MAX];

  dntw_pkg::back_state_t        state_r, state_nxt;
  dntw_pkg::job_t               cur_r;
  logic [dntw_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic                         b_v_r, b_v_nxt;

  logic [7:0]                   rd0_r, rd1_r, c0_r, c1_r;
  logic                         sel0_r, sel1_r, last_r;
  logic [1:0]                   cnt_r;
  dntw_pkg::status_t            st_r;

  logic                         can_issue, issue, done;
  logic [dntw_pkg::POS_W-1:0]   n_bytes, pos1;
  logic [dntw_pkg::POS_W-1:0]   len_w;
  logic [7:0]                   c0, c1;
  logic                         sel0, sel1, two, is_fin;
  logic [1:0]                   cnt;
  logic [AW-1:0]                idx0, idx1, widx;

  assign can_issue = !b_v_r || out_ch.ready;
  assign issue     = (state_r == dntw_pkg::BK_RUN) && can_issue;
  assign pop       = (state_r == dntw_pkg::BK_IDLE) && !q_empty;

  assign len_w   = {1'b0, cur_r.len};
  assign n_bytes = len_w + dntw_pkg::POS_W'(1) + {6'd0, cur_r.fin};
  assign pos1    = pos_r + 1'b1;

  always_comb begin
    c0     = 8'd0;
    c1     = 8'd0;
    sel0   = 1'b0;
    sel1   = 1'b0;
    cnt    = 2'd1;
    is_fin = 1'b1;
    done   = 1'b1;
    two    = 1'b0;
    unique case (cur_r.kind)
      dntw_pkg::JOB_LABEL: begin
        // first byte: length, label byte or terminator
        if (pos_r == '0) begin
          c0 = {2'b00, cur_r.len};
        end else if (pos_r <= len_w) begin
          sel0 = 1'b1;
        end
        two  = (pos1 < n_bytes);
        sel1 = two && (pos1 <= len_w);
        cnt  = two ? 2'd2 : 2'd1;
        done = ((pos_r + dntw_pkg::POS_W'(2)) >= n_bytes);
        is_fin = cur_r.fin && done;
      end
      dntw_pkg::JOB_ROOT: begin
        cnt = 2'd1;
      end
      dntw_pkg::JOB_ERR: begin
        cnt = 2'd0;
      end
      default: begin
        cnt = 2'd0;
      end
    endcase
  end

  assign idx0 = AW'(LABEL_MAX * int'(cur_r.bank) + int'(pos_r) - 1);
  assign idx1 = AW'(LABEL_MAX * int'(cur_r.bank) + int'(pos_r));
  assign widx = AW'(LABEL_MAX * int'(wr.bank) + int'(wr.addr));

  assign rel.en   = issue && done && (cur_r.kind == dntw_pkg::JOB_LABEL);
  assign rel.bank = cur_r.bank;

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    b_v_nxt   = b_v_r;
    if (b_v_r && out_ch.ready) begin
      b_v_nxt = 1'b0;
    end
    unique case (state_r)
      dntw_pkg::BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = dntw_pkg::BK_RUN;
          pos_nxt   = '0;
        end
      end
      dntw_pkg::BK_RUN: begin
        if (issue) begin
          b_v_nxt = 1'b1;
          pos_nxt = pos_r + dntw_pkg::POS_W'(2);
          if (done) begin
            state_nxt = dntw_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = dntw_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dntw_pkg::BK_IDLE;
      pos_r   <= '0;
      b_v_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      b_v_r   <= b_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= q_job;
    end
    if (issue) begin
      c0_r   <= c0;
      c1_r   <= c1;
      sel0_r <= sel0;
      sel1_r <= sel1;
      cnt_r  <= cnt;
      last_r <= is_fin;
      st_r   <= cur_r.status;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[widx] <= wr.data;
    end
    if (issue) begin
      rd0_r <= mem[idx0];
      rd1_r <= mem[idx1];
    end
  end

  assign out_ch.valid       = b_v_r;
  assign out_ch.first_byte  = sel0_r ? rd0_r : c0_r;
  assign out_ch.second_byte = sel1_r ? rd1_r : c1_r;
  assign out_ch.byte_count  = cnt_r;
  assign out_ch.is_last_res = last_r;
  assign out_ch.status      = st_r;

`ifndef ASSERT_OFF
  a_rel_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    rel.en |-> (state_r == dntw_pkg::BK_RUN))
    else $error("bank released outside a label drain");
  a_err_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    b_v_r |-> ((cnt_r == 2'd0) == (st_r != dntw_pkg::ST_OK)))
    else $error("byte count disagrees with status");
`endif

endmodule

// File: hw/rtl/dns_name_text_to_wire.sv
// Dotted domain name text to DNS wire format.
// in_ch takes one character per request (char_code, is_last on the final one).
// out_ch gives wire bytes in pairs: a length byte, the label bytes and, at the
// end of the name, a zero terminator; byte_count tells how many are valid.
// A lone dot gives the root name (one zero byte). An empty label, a label over
// LABEL_MAX or a name over NAME_MAX gives one result with byte_count 0, the
// status and is_last_res set; the rest of that name is then dropped.
// The front end takes one character per cycle, unless stalled, into one of
// two label banks. At a label end it queues a job; the back end drains the
// label two bytes per cycle while the receiver takes them, from a two-read
// label memory. Each job passes the queue and the idle state before it is issued.
// Input stalls only while the bank it would fill is still being drained or
// the two-entry job queue is full.
// A stalled receiver holds the current result steady; the back end then stops
// and, once the queue fills, so does the input.
// Synchronous active-low reset empties the queue and starts a fresh name; the
// label memory holds no reset value.
module dns_name_text_to_wire #(
  parameter int LABEL_MAX = 63,
  parameter int NAME_MAX  = 255
) (
  input  logic       clk,
  input  logic       rst_n,
  dntw_char_if.sink  in_ch,
  dntw_res_if.source out_ch
);

  logic                q_full, q_empty, push, pop;
  dntw_pkg::job_t      push_job, pop_job;
  dntw_pkg::store_wr_t wr;
  dntw_pkg::bank_rel_t rel;

  dntw_front #(
    .LABEL_MAX (LABEL_MAX),
    .NAME_MAX  (NAME_MAX)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job),
    .wr       (wr),
    .rel      (rel)
  );

  dntw_job_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  dntw_back #(
    .LABEL_MAX (LABEL_MAX)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .q_empty (q_empty),
    .q_job   (pop_job),
    .pop     (pop),
    .rel     (rel),
    .out_ch  (out_ch)
  );

endmodule
